// ===== rtl/bsf_pkg.sv =====
// ----------------------------------------------------------------------------
// bsf_pkg: shared types and constants of the bit-stream framer
// Holds the config bundle, status bundles, frame byte positions and the
// CRC-8 (poly 0x07) byte update.
// ----------------------------------------------------------------------------
package bsf_pkg;

  localparam int BYTE_W          = 8;
  localparam int SEQ_W           = 16;
  localparam int CFG_W           = 16;
  localparam int POS_W           = 4;
  localparam int HELD_W          = 3;
  localparam int QUEUE_DEPTH_DEF = 2;

  localparam logic [BYTE_W-1:0] CRC_POLY = 8'h07;

  // Reset values of the configuration registers
  localparam logic [BYTE_W-1:0] PREAMBLE_RST = 8'hFF;
  localparam logic [BYTE_W-1:0] KIND_RST     = 8'h01;
  localparam logic [SEQ_W-1:0]  SIZE_RST     = 16'd2;
  localparam logic [SEQ_W-1:0]  LIMIT_RST    = 16'd8000;
  localparam logic [SEQ_W-1:0]  SEQ_RST      = 16'd1;

  typedef enum logic [1:0] {
    REG_PREAMBLE = 2'd0,
    REG_KIND     = 2'd1,
    REG_SIZE     = 2'd2,
    REG_LIMIT    = 2'd3
  } reg_index_t;

  // Byte positions inside one frame
  localparam logic [POS_W-1:0] POS_PREAMBLE = 4'd0;
  localparam logic [POS_W-1:0] POS_SEQ_HI   = 4'd1;
  localparam logic [POS_W-1:0] POS_SEQ_LO   = 4'd2;
  localparam logic [POS_W-1:0] POS_KIND     = 4'd3;
  localparam logic [POS_W-1:0] POS_SIZE_HI  = 4'd4;
  localparam logic [POS_W-1:0] POS_SIZE_LO  = 4'd5;
  localparam logic [POS_W-1:0] POS_PAYLOAD  = 4'd6;
  localparam logic [POS_W-1:0] POS_FCS      = 4'd7;
  localparam logic [POS_W-1:0] POS_CRC      = 4'd8;

  typedef struct packed {
    logic [BYTE_W-1:0] preamble_byte;
    logic [BYTE_W-1:0] frame_kind;
    logic [SEQ_W-1:0]  size_word;
    logic [SEQ_W-1:0]  sequence_limit;
  } cfg_t;

  typedef struct packed {
    logic             active;
    logic [POS_W-1:0] pos;
  } back_status_t;

  // Fold one byte into the running CRC, MSB first
  function automatic logic [BYTE_W-1:0] crc8_byte(input logic [BYTE_W-1:0] crc_in,
                                                  input logic [BYTE_W-1:0] data);
    logic [BYTE_W-1:0] acc;
    acc = crc_in ^ data;
    for (int b = 0; b < BYTE_W; b++) begin
      if (acc[BYTE_W-1]) begin
        acc = (acc << 1) ^ CRC_POLY;
      end else begin
        acc = acc << 1;
      end
    end
    return acc;
  endfunction

endpackage

// ===== rtl/bsf_front.sv =====
// ----------------------------------------------------------------------------
// bsf_front: bit gatherer
// Packs incoming bits into payload bytes and pushes each finished byte,
// including the aligned flush of a partial byte at stream end.
// ----------------------------------------------------------------------------
module bsf_front import bsf_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              bit_valid,
  output logic              bit_ready,
  input  logic              data_bit,
  input  logic              stream_end,
  input  logic              q_full,
  output logic              push,
  output logic [BYTE_W-1:0] push_data,
  output logic [HELD_W-1:0] held
);

  logic [BYTE_W-1:0] bit_gather;
  logic [HELD_W-1:0] bits_held;
  logic              accept;
  logic [BYTE_W-1:0] gathered;
  logic [POS_W-1:0]  n;
  logic [HELD_W-1:0] lo_bits;
  logic [BYTE_W-1:0] shifted;
  logic [BYTE_W-1:0] mask;
  logic [BYTE_W-1:0] lo;

  assign bit_ready = !q_full;
  assign accept    = bit_valid && bit_ready;
  assign gathered  = {bit_gather[BYTE_W-2:0], data_bit};
  assign n         = POS_W'(bits_held) + POS_W'(1);
  assign push      = accept && ((n == POS_W'(BYTE_W)) || stream_end);
  assign held      = bits_held;

  // Four bits or fewer sit right-aligned; longer runs split at the fourth bit
  always_comb begin
    lo_bits = HELD_W'(n - POS_W'(4));
    shifted = gathered >> lo_bits;
    mask    = (BYTE_W'(1) << lo_bits) - BYTE_W'(1);
    lo      = gathered & mask;
    if (n <= POS_W'(4)) begin
      push_data = {4'b0000, gathered[3:0]};
    end else begin
      push_data = {shifted[3:0], lo[3:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_gather <= '0;
      bits_held  <= '0;
    end else if (accept) begin
      if (push) begin
        bit_gather <= '0;
        bits_held  <= '0;
      end else begin
        bit_gather <= gathered;
        bits_held  <= n[HELD_W-1:0];
      end
    end
  end

endmodule

// ===== rtl/bsf_queue.sv =====
// ----------------------------------------------------------------------------
// bsf_queue: payload byte queue
// Small show-ahead FIFO between the bit gatherer and the frame builder.
// ----------------------------------------------------------------------------
module bsf_queue import bsf_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  logic [BYTE_W-1:0]          push_data,
  input  logic                       pop,
  output logic [BYTE_W-1:0]          pop_data,
  output logic                       full,
  output logic                       empty,
  output logic [$clog2(DEPTH+1)-1:0] level
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [BYTE_W-1:0] mem [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;

  assign full     = (level == CNT_W'(DEPTH));
  assign empty    = (level == '0);
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      case ({push, pop})
        2'b10:   level <= level + CNT_W'(1);
        2'b01:   level <= level - CNT_W'(1);
        default: level <= level;
      endcase
    end
  end

endmodule

// ===== rtl/bsf_back.sv =====
// ----------------------------------------------------------------------------
// bsf_back: frame builder
// Takes one payload byte per frame and streams the nine frame bytes through
// an output register, folding the CRC byte by byte.
// ----------------------------------------------------------------------------
module bsf_back import bsf_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  cfg_t              cfg,
  input  logic              q_empty,
  input  logic [BYTE_W-1:0] q_data,
  output logic              pop,
  output logic              frame_valid,
  input  logic              frame_ready,
  output logic [BYTE_W-1:0] frame_byte,
  output logic              frame_last,
  output back_status_t      status
);

  logic              active;
  logic [POS_W-1:0]  pos;
  logic [SEQ_W-1:0]  seq_count;
  logic [BYTE_W-1:0] payload;
  logic [BYTE_W-1:0] crc;
  logic              slot_free;
  logic              emit;
  logic              finishing;
  logic [BYTE_W-1:0] byte_sel;

  assign slot_free = !frame_valid || frame_ready;
  assign emit      = active && slot_free;
  assign finishing = emit && (pos == POS_CRC);
  assign pop       = (!active || finishing) && !q_empty;
  assign status    = '{active: active, pos: pos};

  always_comb begin
    unique case (pos)
      POS_PREAMBLE: byte_sel = cfg.preamble_byte;
      POS_SEQ_HI:   byte_sel = seq_count[SEQ_W-1:BYTE_W];
      POS_SEQ_LO:   byte_sel = seq_count[BYTE_W-1:0];
      POS_KIND:     byte_sel = cfg.frame_kind;
      POS_SIZE_HI:  byte_sel = cfg.size_word[SEQ_W-1:BYTE_W];
      POS_SIZE_LO:  byte_sel = cfg.size_word[BYTE_W-1:0];
      POS_PAYLOAD:  byte_sel = payload;
      POS_FCS:      byte_sel = '0;
      POS_CRC:      byte_sel = crc;
      default:      byte_sel = '0;
    endcase
  end

  // Control: frame sequencing, sequence number and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      active      <= 1'b0;
      pos         <= POS_PREAMBLE;
      seq_count   <= SEQ_RST;
      frame_valid <= 1'b0;
    end else begin
      if (emit) begin
        frame_valid <= 1'b1;
      end else if (frame_ready) begin
        frame_valid <= 1'b0;
      end
      if (emit) begin
        pos <= pos + POS_W'(1);
      end
      if (finishing) begin
        active <= 1'b0;
        pos    <= POS_PREAMBLE;
        if (seq_count >= cfg.sequence_limit) begin
          seq_count <= '0;
        end else begin
          seq_count <= seq_count + SEQ_W'(1);
        end
      end
      if (pop) begin
        active <= 1'b1;
        pos    <= POS_PREAMBLE;
      end
    end
  end

  // Data: payload, running CRC and output byte
  always_ff @(posedge clk) begin
    if (emit) begin
      frame_byte <= byte_sel;
      frame_last <= (pos == POS_CRC);
      if (pos < POS_FCS) begin
        crc <= crc8_byte(crc, byte_sel);
      end
    end
    if (pop) begin
      payload <= q_data;
      crc     <= '0;
    end
  end

endmodule

// ===== rtl/bit_stream_framer_crc8_core.sv =====
// ----------------------------------------------------------------------------
// bit_stream_framer_crc8_core: bit-stream framer with CRC-8
// Path: the bit that completes (or ends) a payload byte is queued; an idle
//   builder pops it and sends the frame's first byte via the output register.
// Throughput: one input bit per cycle while the payload queue has room; one
//   frame byte per cycle while the receiver is ready; nine bytes per frame.
// Reset: synchronous; clears the gather, queue and output valid, loads
//   register defaults and restarts the sequence number at one.
// ----------------------------------------------------------------------------
module bit_stream_framer_crc8_core import bsf_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  // Bit request channel
  input  logic              bit_valid,
  output logic              bit_ready,
  input  logic              data_bit,
  input  logic              stream_end,
  // Frame byte channel
  output logic              frame_valid,
  input  logic              frame_ready,
  output logic [BYTE_W-1:0] frame_byte,
  output logic              frame_last,
  // Configuration write port
  input  logic              cfg_write,
  input  reg_index_t        cfg_index,
  input  logic [CFG_W-1:0]  cfg_data
);

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cfg_t              cfg;
  logic              q_push;
  logic [BYTE_W-1:0] q_push_data;
  logic              q_pop;
  logic [BYTE_W-1:0] q_pop_data;
  logic              q_full;
  logic              q_empty;
  logic [CNT_W-1:0]  q_level;
  logic [HELD_W-1:0] held;
  back_status_t      back_st;

  // Configuration registers; the user must see that they are written only while
  // the framer is idle, so the builder reads them directly; the block does not check.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.preamble_byte  <= PREAMBLE_RST;
      cfg.frame_kind     <= KIND_RST;
      cfg.size_word      <= SIZE_RST;
      cfg.sequence_limit <= LIMIT_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_PREAMBLE: cfg.preamble_byte  <= cfg_data[BYTE_W-1:0];
        REG_KIND:     cfg.frame_kind     <= cfg_data[BYTE_W-1:0];
        REG_SIZE:     cfg.size_word      <= cfg_data;
        REG_LIMIT:    cfg.sequence_limit <= cfg_data;
        default:      cfg.sequence_limit <= cfg.sequence_limit;
      endcase
    end
  end

  // Front: gather bits, push payload bytes; stall input when the queue fills
  bsf_front u_front (
    .clk        (clk),
    .rst        (rst),
    .bit_valid  (bit_valid),
    .bit_ready  (bit_ready),
    .data_bit   (data_bit),
    .stream_end (stream_end),
    .q_full     (q_full),
    .push       (q_push),
    .push_data  (q_push_data),
    .held       (held)
  );

  // Queue decouples bit gathering from frame emission
  bsf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_push_data),
    .pop       (q_pop),
    .pop_data  (q_pop_data),
    .full      (q_full),
    .empty     (q_empty),
    .level     (q_level)
  );

  // Back: build and stream each frame through the output register
  bsf_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .q_empty     (q_empty),
    .q_data      (q_pop_data),
    .pop         (q_pop),
    .frame_valid (frame_valid),
    .frame_ready (frame_ready),
    .frame_byte  (frame_byte),
    .frame_last  (frame_last),
    .status      (back_st)
  );

  // Queue never overfills
  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    q_level <= CNT_W'(QUEUE_DEPTH))
    else $error("payload queue level above depth");

  // A shown CRC byte means the builder has wrapped to the frame start
  a_last_wraps: assert property (@(posedge clk) disable iff (rst)
    frame_valid && frame_last |-> back_st.pos == POS_PREAMBLE)
    else $error("builder position not reset after CRC byte");

  // An accepted final bit leaves no gathered bits behind
  a_end_flushes: assert property (@(posedge clk) disable iff (rst)
    bit_valid && bit_ready && stream_end |=> held == '0)
    else $error("gather not cleared after stream end");

  // A pop happens only when the builder is idle or on its last byte
  a_pop_clean: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !back_st.active || back_st.pos == POS_CRC)
    else $error("payload popped mid-frame");

endmodule
